>>> design/spt_pkg.sv
// Shared types, constants and helper functions of the sphere patch tessellator.
package spt_pkg;

	// default parameter values
	localparam int RES_BITS_DEF    = 10;
	localparam int SAMPLE_BITS_DEF = 16;

	// configuration port
	localparam int CFG_W     = 18;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_RES  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_RES = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_STA  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_END  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_STA = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_END = 3'd5;

	// register reset values
	localparam logic [10:0] RST_WIDTH_RES  = 11'd16;
	localparam logic [10:0] RST_HEIGHT_RES = 11'd8;
	localparam logic [17:0] RST_WIDTH_STA  = 18'h00000;
	localparam logic [17:0] RST_WIDTH_END  = 18'h10000;
	localparam logic [17:0] RST_HEIGHT_STA = 18'h3C000;
	localparam logic [17:0] RST_HEIGHT_END = 18'h04000;

	// sweep caps in turn units
	localparam logic signed [18:0] FULL_TURN = 19'sd65536;
	localparam logic signed [18:0] HALF_TURN = 19'sd32768;

	// sine polynomial coefficients
	localparam logic [16:0] POLY_A = 17'd102944;
	localparam logic [15:0] POLY_B = 16'd42048;
	localparam logic [12:0] POLY_C = 13'd4640;

	// vertex slots
	localparam logic [2:0] SLOT_FIRST = 3'd0;
	localparam logic [2:0] SLOT_LAST  = 3'd5;

	typedef struct packed {
		logic [9:0] cell_column;
		logic [9:0] cell_row;
	} cell_item_t;

	typedef struct packed {
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_z;
		logic signed [15:0] norm_x;
		logic signed [15:0] norm_y;
		logic signed [15:0] norm_z;
		logic [16:0]        tex_u;
		logic [16:0]        tex_v;
		logic [2:0]         vertex_slot;
		logic               last_vertex;
	} vtx_item_t;

	// side data travelling with each vertex through the divider chain
	typedef struct packed {
		logic [2:0] slot;
		logic       neg_w;
		logic       neg_h;
	} vtx_tag_t;

	// column offset of each slot: a,b,c,a,c,d
	function automatic logic slot_di(input logic [2:0] slot);
		logic r;
		case (slot)
			3'd1, 3'd2, 3'd4: r = 1'b1;
			default:          r = 1'b0;
		endcase
		return r;
	endfunction

	// row offset of each slot
	function automatic logic slot_dj(input logic [2:0] slot);
		logic r;
		case (slot)
			3'd2, 3'd4, 3'd5: r = 1'b1;
			default:          r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

>>> design/sphere_patch_tessellator_core.sv
// Top level of the sphere patch tessellator: front end, divider chain, sine units, output.
//
// A cell (column, row) is taken on the cell channel by a valid/ready transfer;
// the block answers with six vertices on the vtx channel in the order
// a,b,c,a,c,d, one vertex per cycle while vtx_ready allows, the sixth flagged by last_vertex.
// Throughput: one vertex every cycle while the receiver is ready, set by the
// single output channel; a new cell is taken while the previous one's last
// vertex is being issued.
// Path: each vertex passes the front-end register, stage 1, the chain of
// RES_BITS+SAMPLE_BITS+21 division cells, one quotient bit per cell, stage 3,
// the five-stage sine pipeline and the output register.
// Registers are written on the cfg port (cfg_we, cfg_index, cfg_data); unknown indexes
// are ignored. The user must write them only while the block is idle; the block itself
// does not enforce this. Reset clears all valid flags and loads the register defaults.
// When the receiver stalls, the whole pipeline holds and the cell channel
// keeps taking a cell only while it can still be issued.
module sphere_patch_tessellator_core import spt_pkg::*; #(
	parameter int RES_BITS    = RES_BITS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cell_valid,
	output logic                 cell_ready,
	input  cell_item_t           cell_item,
	output logic                 vtx_valid,
	input  logic                 vtx_ready,
	output vtx_item_t            vtx,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int R       = RES_BITS;
	localparam int S       = SAMPLE_BITS;
	localparam int IW      = R + 1;
	localparam int MW      = R + 21;
	localparam int MAG     = R + 19;
	localparam int NW      = R + S + 21;
	localparam int PW      = S + 2;
	localparam int EW      = S + 18;
	localparam int RES_LIM = 1 << R;
	localparam int SPIPE   = 5;

	// configuration registers
	logic [10:0] wres_q, hres_q;
	logic [17:0] wsta_q, wend_q, hsta_q, hend_q;
	logic signed [18:0] sweep_w_q, sweep_h_q;
	logic signed [18:0] dw, dh;
	logic [IW-1:0] wr_eff, hr_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wres_q <= RST_WIDTH_RES;
			hres_q <= RST_HEIGHT_RES;
			wsta_q <= RST_WIDTH_STA;
			wend_q <= RST_WIDTH_END;
			hsta_q <= RST_HEIGHT_STA;
			hend_q <= RST_HEIGHT_END;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WIDTH_RES:  wres_q <= cfg_data[10:0];
				CFG_HEIGHT_RES: hres_q <= cfg_data[10:0];
				CFG_WIDTH_STA:  wsta_q <= cfg_data;
				CFG_WIDTH_END:  wend_q <= cfg_data;
				CFG_HEIGHT_STA: hsta_q <= cfg_data;
				CFG_HEIGHT_END: hend_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective resolutions: zero acts as one, capped at 2^RES_BITS
	always_comb begin
		if (wres_q == 11'd0) begin
			wr_eff = IW'(1);
		end else if (32'(wres_q) > RES_LIM) begin
			wr_eff = IW'(RES_LIM);
		end else begin
			wr_eff = IW'(wres_q);
		end
		if (hres_q == 11'd0) begin
			hr_eff = IW'(1);
		end else if (32'(hres_q) > RES_LIM) begin
			hr_eff = IW'(RES_LIM);
		end else begin
			hr_eff = IW'(hres_q);
		end
	end

	// capped sweeps, registered off the config path
	assign dw = signed'({wend_q[17], wend_q}) - signed'({wsta_q[17], wsta_q});
	assign dh = signed'({hend_q[17], hend_q}) - signed'({hsta_q[17], hsta_q});

	always_ff @(posedge clk) begin
		sweep_w_q <= (dw > FULL_TURN) ? FULL_TURN : dw;
		sweep_h_q <= (dh > HALF_TURN) ? HALF_TURN : dh;
	end

	// pipeline advance: hold everything while the output waits
	logic adv;
	assign adv = !vtx_valid || vtx_ready;

	// front end: hold the current cell and step through its six slots
	logic          busy_q;
	logic [2:0]    slot_q;
	logic [IW-1:0] col_q, row_q;
	logic          issue, take;
	logic [IW-1:0] col_c, row_c;

	assign issue      = busy_q && adv;
	assign cell_ready = !busy_q || (adv && slot_q == SLOT_LAST);
	assign take       = cell_valid && cell_ready;

	always_comb begin
		col_c = (32'(cell_item.cell_column) > 32'(wr_eff) - 1) ? IW'(wr_eff - IW'(1))
			: IW'(cell_item.cell_column);
		row_c = (32'(cell_item.cell_row) > 32'(hr_eff) - 1) ? IW'(hr_eff - IW'(1))
			: IW'(cell_item.cell_row);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			slot_q <= SLOT_FIRST;
		end else if (take) begin
			busy_q <= 1'b1;
			slot_q <= SLOT_FIRST;
		end else if (issue) begin
			if (slot_q == SLOT_LAST) begin
				busy_q <= 1'b0;
			end
			slot_q <= slot_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			col_q <= col_c;
			row_q <= row_c;
		end
	end

	// stage 1: corner indexes and index times sweep
	logic                 valid_s1;
	logic [2:0]           slot_s1;
	logic [IW-1:0]        i_s1, j_s1;
	logic signed [MW-1:0] m_w_s1, m_h_s1;
	logic [IW-1:0]        i_n, j_n;

	assign i_n = col_q + IW'(slot_di(slot_q));
	assign j_n = row_q + IW'(slot_dj(slot_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			slot_s1 <= slot_q;
			i_s1    <= i_n;
			j_s1    <= j_n;
			m_w_s1  <= MW'(signed'({1'b0, i_n})) * MW'(sweep_w_q);
			m_h_s1  <= MW'(signed'({1'b0, j_n})) * MW'(sweep_h_q);
		end
	end

	// chain input: magnitudes scaled to phase precision, sign on the tag
	logic [MW-1:0] abs_w, abs_h;
	assign abs_w = m_w_s1[MW-1] ? MW'(-m_w_s1) : MW'(m_w_s1);
	assign abs_h = m_h_s1[MW-1] ? MW'(-m_h_s1) : MW'(m_h_s1);

	logic                 c_valid [NW+1];
	vtx_tag_t             c_tag   [NW+1];
	logic [3:0][R-1:0]    c_rem   [NW+1];
	logic [3:0][NW-1:0]   c_nq    [NW+1];

	always_comb begin
		c_valid[0]    = valid_s1;
		c_tag[0].slot  = slot_s1;
		c_tag[0].neg_w = m_w_s1[MW-1];
		c_tag[0].neg_h = m_h_s1[MW-1];
		c_rem[0]      = '0;
		c_nq[0][0]    = {abs_w[MAG-1:0], {PW{1'b0}}};
		c_nq[0][1]    = NW'({i_s1, 16'b0});
		c_nq[0][2]    = {abs_h[MAG-1:0], {PW{1'b0}}};
		c_nq[0][3]    = NW'({j_s1, 16'b0});
	end

	// divider chain, one quotient bit per cell
	for (genvar k = 0; k < NW; k++) begin : g_div
		spt_div_cell #(
			.RES_BITS (R),
			.NUM_W    (NW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (adv),
			.div_w   (wr_eff),
			.div_h   (hr_eff),
			.valid_i (c_valid[k]),
			.tag_i   (c_tag[k]),
			.rem_i   (c_rem[k]),
			.nq_i    (c_nq[k]),
			.valid_o (c_valid[k+1]),
			.tag_o   (c_tag[k+1]),
			.rem_o   (c_rem[k+1]),
			.nq_o    (c_nq[k+1])
		);
	end

	// stage 3: floor quotient, add start angle, take phases
	logic          valid_s3;
	vtx_tag_t      tag_s3;
	logic [16:0]   tu_s3, tv_s3;
	logic [PW-1:0] ph_ws_s3, ph_wc_s3, ph_hs_s3, ph_hc_s3;
	logic [NW-1:0] qw, qh;
	logic [EW-1:0] qsw, qsh, ext_w, ext_h;
	logic [PW-1:0] pw_n, ph_n;

	always_comb begin
		qw = c_nq[NW][0];
		qh = c_nq[NW][2];
		if (c_tag[NW].neg_w) begin
			qsw = (c_rem[NW][0] != '0) ? EW'(~qw) : EW'(-qw);
		end else begin
			qsw = EW'(qw);
		end
		if (c_tag[NW].neg_h) begin
			qsh = (c_rem[NW][2] != '0) ? EW'(~qh) : EW'(-qh);
		end else begin
			qsh = EW'(qh);
		end
		ext_w = EW'({wsta_q[15:0], {PW{1'b0}}}) + qsw;
		ext_h = EW'({hsta_q[15:0], {PW{1'b0}}}) + qsh;
		pw_n  = ext_w[EW-1:16];
		ph_n  = ext_h[EW-1:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= c_valid[NW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s3   <= c_tag[NW];
			tu_s3    <= c_nq[NW][1][16:0];
			tv_s3    <= c_nq[NW][3][16:0];
			ph_ws_s3 <= pw_n;
			ph_wc_s3 <= pw_n + (PW'(1) << S);
			ph_hs_s3 <= ph_n;
			ph_hc_s3 <= ph_n + (PW'(1) << S);
		end
	end

	// sine and cosine of both angles
	logic signed [15:0] sin_w, cos_w, sin_h, cos_h;

	spt_sine #(.SAMPLE_BITS(S)) u_sin_w (.clk(clk), .en(adv), .phase(ph_ws_s3), .value(sin_w));
	spt_sine #(.SAMPLE_BITS(S)) u_cos_w (.clk(clk), .en(adv), .phase(ph_wc_s3), .value(cos_w));
	spt_sine #(.SAMPLE_BITS(S)) u_sin_h (.clk(clk), .en(adv), .phase(ph_hs_s3), .value(sin_h));
	spt_sine #(.SAMPLE_BITS(S)) u_cos_h (.clk(clk), .en(adv), .phase(ph_hc_s3), .value(cos_h));

	// side data delayed alongside the sine pipeline
	logic        e_valid [SPIPE];
	vtx_tag_t    e_tag   [SPIPE];
	logic [16:0] e_tu    [SPIPE];
	logic [16:0] e_tv    [SPIPE];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SPIPE; k++) begin
				e_valid[k] <= 1'b0;
			end
		end else if (adv) begin
			e_valid[0] <= valid_s3;
			for (int k = 1; k < SPIPE; k++) begin
				e_valid[k] <= e_valid[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			e_tag[0] <= tag_s3;
			e_tu[0]  <= tu_s3;
			e_tv[0]  <= tv_s3;
			for (int k = 1; k < SPIPE; k++) begin
				e_tag[k] <= e_tag[k-1];
				e_tu[k]  <= e_tu[k-1];
				e_tv[k]  <= e_tv[k-1];
			end
		end
	end

	// Q15 products, rounded half up
	logic signed [32:0] px_p, pz_p;
	logic signed [15:0] px_n, pz_n;

	always_comb begin
		px_p = 33'(cos_h) * 33'(sin_w) + 33'sd16384;
		pz_p = 33'(cos_h) * 33'(cos_w) + 33'sd16384;
		px_n = 16'(px_p >>> 15);
		pz_n = 16'(pz_p >>> 15);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vtx_valid <= 1'b0;
		end else if (adv) begin
			vtx_valid <= e_valid[SPIPE-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vtx.pos_x       <= px_n;
			vtx.pos_y       <= sin_h;
			vtx.pos_z       <= pz_n;
			vtx.norm_x      <= px_n;
			vtx.norm_y      <= sin_h;
			vtx.norm_z      <= pz_n;
			vtx.tex_u       <= e_tu[SPIPE-1];
			vtx.tex_v       <= e_tv[SPIPE-1];
			vtx.vertex_slot <= e_tag[SPIPE-1].slot;
			vtx.last_vertex <= (e_tag[SPIPE-1].slot == SLOT_LAST);
		end
	end

endmodule

>>> design/spt_div_cell.sv
// Four-lane restoring division cell, one quotient bit per lane per enabled cycle.
module spt_div_cell import spt_pkg::*; #(
	parameter int RES_BITS = RES_BITS_DEF,
	parameter int NUM_W    = RES_BITS_DEF + SAMPLE_BITS_DEF + 21
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic [RES_BITS:0]             div_w,
	input  logic [RES_BITS:0]             div_h,
	input  logic                          valid_i,
	input  vtx_tag_t                      tag_i,
	input  logic [3:0][RES_BITS-1:0]      rem_i,
	input  logic [3:0][NUM_W-1:0]         nq_i,
	output logic                          valid_o,
	output vtx_tag_t                      tag_o,
	output logic [3:0][RES_BITS-1:0]      rem_o,
	output logic [3:0][NUM_W-1:0]         nq_o
);

	logic [3:0][RES_BITS-1:0] rem_n;
	logic [3:0][NUM_W-1:0]    nq_n;
	logic [3:0][RES_BITS:0]   sh;
	logic [3:0][RES_BITS:0]   dv;
	logic [3:0]               ge;

	// lanes 0,1 divide by the width resolution, lanes 2,3 by the height one
	always_comb begin
		for (int l = 0; l < 4; l++) begin
			dv[l]    = (l < 2) ? div_w : div_h;
			sh[l]    = {rem_i[l], nq_i[l][NUM_W-1]};
			ge[l]    = (sh[l] >= dv[l]);
			rem_n[l] = ge[l] ? RES_BITS'(sh[l] - dv[l]) : sh[l][RES_BITS-1:0];
			nq_n[l]  = {nq_i[l][NUM_W-2:0], ge[l]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else if (en) begin
			valid_o <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_o <= tag_i;
			rem_o <= rem_n;
			nq_o  <= nq_n;
		end
	end

endmodule

>>> design/spt_sine.sv
// Five-stage pipelined polynomial sine, phase in quarter-turn units of 2^SAMPLE_BITS.
module spt_sine import spt_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic [SAMPLE_BITS+1:0]   phase,
	output logic signed [15:0]       value
);

	localparam int S = SAMPLE_BITS;

	logic [1:0]     quad_a, quad_b, quad_c, quad_d;
	logic [S:0]     t_n, t_a, t_b, t_c;
	logic [2*S+1:0] tt_a;
	logic [S:0]     t2_n, t2_b;
	logic [S+13:0]  pc_b;
	logic [15:0]    k1_n;
	logic [S+16:0]  p2_c;
	logic [16:0]    k2_n;
	logic [S+17:0]  p3_d;
	logic [17:0]    r_n, rr_n;
	logic [14:0]    mag_n;

	// fold the phase into the first quadrant
	always_comb begin
		t_n = phase[S] ? ((S+1)'(1) << S) - (S+1)'(phase[S-1:0])
			: (S+1)'(phase[S-1:0]);
	end

	assign t2_n = tt_a[2*S:S];
	assign k1_n = POLY_B - 16'(pc_b[S+13:S]);
	assign k2_n = POLY_A - 17'(p2_c[S+16:S]);

	// round to Q1.15 and saturate
	always_comb begin
		r_n   = p3_d[S+17:S];
		rr_n  = 18'(r_n + 18'd1) >> 1;
		mag_n = (rr_n > 18'd32767) ? 15'h7FFF : rr_n[14:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quad_a <= phase[S+1:S];
			t_a    <= t_n;
			tt_a   <= (2*S+2)'(t_n) * (2*S+2)'(t_n);
			quad_b <= quad_a;
			t_b    <= t_a;
			t2_b   <= t2_n;
			pc_b   <= (S+14)'(POLY_C) * (S+14)'(t2_n);
			quad_c <= quad_b;
			t_c    <= t_b;
			p2_c   <= (S+17)'(t2_b) * (S+17)'(k1_n);
			quad_d <= quad_c;
			p3_d   <= (S+18)'(t_c) * (S+18)'(k2_n);
			value  <= quad_d[1] ? -16'({1'b0, mag_n}) : 16'({1'b0, mag_n});
		end
	end

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench of the sphere patch tessellator core.
module tb;
	import spt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SB = SAMPLE_BITS_DEF;
	localparam int WD_LIMIT = 4000;

	// register indexes outside the map
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cell_valid = 1'b0;
	logic cell_ready;
	cell_item_t cell_item = '0;
	logic vtx_valid;
	logic vtx_ready = 1'b0;
	vtx_item_t vtx;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	sphere_patch_tessellator_core i_dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor copy of the registers
	logic [10:0] m_wres, m_hres;
	logic signed [17:0] m_wsta, m_wend, m_hsta, m_hend;

	cell_item_t cells_pending[$];
	vtx_item_t vertices_due[$];
	int n_errors = 0;
	bit hold_cells = 0;

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		n_errors++;
	endtask

	function automatic longint eff_res(input logic [10:0] r);
		if (r == 0) return 1;
		if (r > 1024) return 1024;
		return r;
	endfunction

	function automatic longint floor_div(input longint n, input longint d);
		longint q = n / d;
		if ((n % d) != 0 && n < 0) q -= 1;
		return q;
	endfunction

	// angle of a corner as a phase of 2^(SB+2) units per turn
	function automatic logic [SB+1:0] corner_angle(input longint sta, input longint sw,
			input longint idx, input longint res);
		longint scale = longint'(1) << (SB + 2);
		longint e = sta * scale + floor_div(idx * sw * scale, res);
		return (SB+2)'(e >>> 16);
	endfunction

	function automatic longint sin_q15(input logic [SB+1:0] ph);
		longint quarter = longint'(1) << SB;
		longint quad = ph[SB+1:SB];
		longint x = ph[SB-1:0];
		longint t, t2, k, r;
		t = quad[0] ? quarter - x : x;
		t2 = (t * t) >> SB;
		k = 42048 - ((4640 * t2) >> SB);
		k = 102944 - ((t2 * k) >> SB);
		r = ((t * k) >> SB);
		r = (r + 1) >> 1;
		if (r > 32767) r = 32767;
		return quad[1] ? -r : r;
	endfunction

	function automatic longint cos_q15(input logic [SB+1:0] ph);
		logic [SB+1:0] p2 = ph + (SB+2)'(1 << SB);
		return sin_q15(p2);
	endfunction

	function automatic longint mul_round(input longint a, input longint b);
		return (a * b + 16384) >>> 15;
	endfunction

	// six vertices of one cell, pushed onto the expected queue
	task automatic predict_cell(input cell_item_t c);
		bit di[6] = '{0, 1, 1, 0, 1, 0};
		bit dj[6] = '{0, 0, 1, 0, 1, 1};
		longint wr = eff_res(m_wres);
		longint hr = eff_res(m_hres);
		longint col = c.cell_column, row = c.cell_row;
		longint wsw = longint'(m_wend) - longint'(m_wsta);
		longint hsw = longint'(m_hend) - longint'(m_hsta);
		longint i, j, ch;
		logic [SB+1:0] pw, phh;
		vtx_item_t v;
		if (wsw > 65536) wsw = 65536;
		if (hsw > 32768) hsw = 32768;
		if (col > wr - 1) col = wr - 1;
		if (row > hr - 1) row = hr - 1;
		for (int s = 0; s < 6; s++) begin
			i = col + di[s];
			j = row + dj[s];
			pw = corner_angle(m_wsta, wsw, i, wr);
			phh = corner_angle(m_hsta, hsw, j, hr);
			ch = cos_q15(phh);
			v.pos_x = 16'(mul_round(ch, sin_q15(pw)));
			v.pos_y = 16'(sin_q15(phh));
			v.pos_z = 16'(mul_round(ch, cos_q15(pw)));
			v.norm_x = v.pos_x;
			v.norm_y = v.pos_y;
			v.norm_z = v.pos_z;
			v.tex_u = 17'((i << 16) / wr);
			v.tex_v = 17'((j << 16) / hr);
			v.vertex_slot = 3'(s);
			v.last_vertex = (3'(s) == SLOT_LAST);
			vertices_due.push_back(v);
		end
	endtask

	// cell driver
	int cell_gap = 0;
	always @(posedge clk) begin
		if (cell_valid && cell_ready) begin
			predict_cell(cell_item);
			cell_gap = $urandom_range(0, 11);
			if ($urandom_range(0, 3) == 0) cell_gap = 0;
		end
		if (!(cell_valid && !cell_ready)) begin
			if (cell_gap > 0) begin
				cell_gap--;
				cell_valid <= 1'b0;
			end else if (cells_pending.size() != 0 && !hold_cells) begin
				cell_item <= cells_pending.pop_front();
				cell_valid <= 1'b1;
			end else begin
				cell_valid <= 1'b0;
			end
		end
	end

	// vertex monitor with random receiver stalls
	int vtx_stall = 0;
	always @(posedge clk) begin
		if (vtx_valid && vtx_ready) begin
			if (vertices_due.size() == 0) begin
				report("unexpected vertex", vtx.vertex_slot, -1);
			end else begin
				vtx_item_t w;
				w = vertices_due.pop_front();
				if (vtx.pos_x !== w.pos_x) report("pos_x", vtx.pos_x, w.pos_x);
				if (vtx.pos_y !== w.pos_y) report("pos_y", vtx.pos_y, w.pos_y);
				if (vtx.pos_z !== w.pos_z) report("pos_z", vtx.pos_z, w.pos_z);
				if (vtx.norm_x !== w.norm_x) report("norm_x", vtx.norm_x, w.norm_x);
				if (vtx.norm_y !== w.norm_y) report("norm_y", vtx.norm_y, w.norm_y);
				if (vtx.norm_z !== w.norm_z) report("norm_z", vtx.norm_z, w.norm_z);
				if (vtx.tex_u !== w.tex_u) report("tex_u", vtx.tex_u, w.tex_u);
				if (vtx.tex_v !== w.tex_v) report("tex_v", vtx.tex_v, w.tex_v);
				if (vtx.vertex_slot !== w.vertex_slot)
					report("vertex_slot", vtx.vertex_slot, w.vertex_slot);
				if (vtx.last_vertex !== w.last_vertex)
					report("last_vertex", vtx.last_vertex, w.last_vertex);
			end
			vtx_stall = $urandom_range(0, 11);
			if ($urandom_range(0, 3) == 0) vtx_stall = 0;
		end
		if (vtx_stall > 0) begin
			vtx_stall--;
			vtx_ready <= 1'b0;
		end else begin
			vtx_ready <= 1'b1;
		end
	end

	// watchdog on cycles without any transfer
	int quiet = 0;
	always @(posedge clk) begin
		if ((cell_valid && cell_ready) || (vtx_valid && vtx_ready) || !arst_n) quiet = 0;
		else quiet++;
		if (quiet >= WD_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_WIDTH_RES:  m_wres = val[10:0];
			CFG_HEIGHT_RES: m_hres = val[10:0];
			CFG_WIDTH_STA:  m_wsta = val;
			CFG_WIDTH_END:  m_wend = val;
			CFG_HEIGHT_STA: m_hsta = val;
			CFG_HEIGHT_END: m_hend = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait for the pipeline to drain; checked at the falling edge once all updates settle
	task automatic drain();
		while (cells_pending.size() != 0 || cell_valid || vertices_due.size() != 0)
			@(negedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic add_cell(input int c, input int r);
		cell_item_t x;
		x.cell_column = 10'(c);
		x.cell_row = 10'(r);
		cells_pending.push_back(x);
	endtask

	task automatic rand_setting();
		case ($urandom_range(0, 3))
			0: write_reg(CFG_WIDTH_RES, 18'($urandom_range(1, 24)));
			1: write_reg(CFG_WIDTH_RES, 18'($urandom_range(0, 2047)));
			default: write_reg(CFG_WIDTH_RES, 18'($urandom_range(1, 64)));
		endcase
		case ($urandom_range(0, 3))
			0: write_reg(CFG_HEIGHT_RES, 18'($urandom_range(1, 24)));
			1: write_reg(CFG_HEIGHT_RES, 18'($urandom_range(0, 2047)));
			default: write_reg(CFG_HEIGHT_RES, 18'($urandom_range(1, 64)));
		endcase
		write_reg(CFG_WIDTH_STA, 18'($urandom));
		write_reg(CFG_WIDTH_END, 18'($urandom));
		write_reg(CFG_HEIGHT_STA, 18'($urandom));
		write_reg(CFG_HEIGHT_END, 18'($urandom));
	endtask

	initial begin
		m_wres = RST_WIDTH_RES;
		m_hres = RST_HEIGHT_RES;
		m_wsta = RST_WIDTH_STA;
		m_wend = RST_WIDTH_END;
		m_hsta = RST_HEIGHT_STA;
		m_hend = RST_HEIGHT_END;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: reset setting, corners, saturated indexes
		add_cell(0, 0);
		add_cell(15, 7);
		add_cell(1023, 1023);
		add_cell(512, 0);
		add_cell(0, 1023);
		add_cell(7, 3);
		drain();

		// largest sweeps and resolutions, zero resolution, unknown register
		write_reg(CFG_WIDTH_RES, 18'd0);
		write_reg(CFG_HEIGHT_RES, 18'd2047);
		write_reg(CFG_WIDTH_STA, 18'h20000);
		write_reg(CFG_WIDTH_END, 18'h1FFFF);
		write_reg(CFG_HEIGHT_STA, 18'h20000);
		write_reg(CFG_HEIGHT_END, 18'h1FFFF);
		write_reg(CFG_SPARE_A, 18'h3FFFF);
		write_reg(CFG_SPARE_B, 18'h15555);
		add_cell(0, 0);
		add_cell(1023, 1023);
		add_cell(5, 1022);
		add_cell(1023, 1);
		drain();

		// reversed sweeps, full resolution
		write_reg(CFG_WIDTH_RES, 18'd1024);
		write_reg(CFG_HEIGHT_RES, 18'd1);
		write_reg(CFG_WIDTH_STA, 18'h1FFFF);
		write_reg(CFG_WIDTH_END, 18'h20000);
		write_reg(CFG_HEIGHT_STA, 18'd16384);
		write_reg(CFG_HEIGHT_END, 18'h3C000);
		add_cell(0, 0);
		add_cell(1023, 0);
		add_cell(341, 682);
		add_cell(682, 341);
		add_cell(1022, 1023);
		drain();

		// random phases, each with its own setting
		for (int ph = 0; ph < 10; ph++) begin
			rand_setting();
			for (int k = 0; k < 26; k++) begin
				if ($urandom_range(0, 3) == 0)
					add_cell($urandom_range(0, 1023), $urandom_range(0, 1023));
				else
					add_cell($urandom_range(0, int'(eff_res(m_wres))),
						$urandom_range(0, int'(eff_res(m_hres))));
			end
			if (ph == 4) begin
				// let half go, then hold the sender until all vertices are out
				while (cells_pending.size() > 13) @(negedge clk);
				hold_cells = 1;
				while (cell_valid || vertices_due.size() != 0) @(negedge clk);
				hold_cells = 0;
			end
			drain();
		end

		if (n_errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
